@@ rtl/shoc_pkg.sv @@
package shoc_pkg;

    localparam int IMAGE_COLS = 1024;
    localparam int IMAGE_ROWS = 1024;
    localparam logic [15:0] NO_DISPARITY = 16'hFFFF;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_UP_RAY     = 3'd0;
    localparam logic [2:0] REG_AXIS_RAY   = 3'd1;
    localparam logic [2:0] REG_BASELINE   = 3'd2;
    localparam logic [2:0] REG_DISP_CTR   = 3'd3;
    localparam logic [2:0] REG_HGT_OFFSET = 3'd4;
    localparam logic [2:0] REG_MIN_HGT    = 3'd5;
    localparam logic [2:0] REG_MAX_HGT    = 3'd6;
    localparam logic [2:0] REG_MAX_RANGE  = 3'd7;

    localparam int LIN_W      = 33;
    localparam int RANGE_QW   = 31;
    localparam int RANGE_DW   = 26;
    localparam int HGT_QW     = 33;
    localparam int HGT_DW     = 33;

    typedef struct packed {
        logic [9:0]  pixel_col;
        logic [9:0]  pixel_row;
        logic [15:0] disparity;
    } t_pixel;

    typedef struct packed {
        logic               measured;
        logic               obstacle;
        logic signed [31:0] height;
    } t_result;

    typedef struct packed {
        logic [62:0]        up_ray_coeffs;
        logic [62:0]        axis_ray_coeffs;
        logic [39:0]        baseline_num;
        logic signed [24:0] disp_center;
        logic signed [31:0] height_offset;
        logic signed [31:0] min_height;
        logic signed [31:0] max_height;
        logic [30:0]        max_range;
    } t_cfg;

    typedef struct packed {
        logic                    skip;
        logic signed [LIN_W-1:0] u;
        logic signed [LIN_W-1:0] w;
    } t_side_rng;

    typedef struct packed {
        logic skip;
        logic neg;
        logic ovf;
    } t_side_hgt;

endpackage

@@ rtl/shoc_cfg.sv @@
module shoc_cfg
    import shoc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;

    assign idx    = paddr[CFG_ADDR_W-1:3];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg                 <= '0;
            r_cfg.max_range       <= 31'h7FFF_FFFF;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_UP_RAY:     r_cfg.up_ray_coeffs   <= pwdata[62:0];
                REG_AXIS_RAY:   r_cfg.axis_ray_coeffs <= pwdata[62:0];
                REG_BASELINE:   r_cfg.baseline_num    <= pwdata[39:0];
                REG_DISP_CTR:   r_cfg.disp_center     <= pwdata[24:0];
                REG_HGT_OFFSET: r_cfg.height_offset   <= pwdata[31:0];
                REG_MIN_HGT:    r_cfg.min_height      <= pwdata[31:0];
                REG_MAX_HGT:    r_cfg.max_height      <= pwdata[31:0];
                REG_MAX_RANGE:  r_cfg.max_range       <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_UP_RAY:     prdata = {1'b0, r_cfg.up_ray_coeffs};
            REG_AXIS_RAY:   prdata = {1'b0, r_cfg.axis_ray_coeffs};
            REG_BASELINE:   prdata = {24'b0, r_cfg.baseline_num};
            REG_DISP_CTR:   prdata = {39'b0, r_cfg.disp_center};
            REG_HGT_OFFSET: prdata = {32'b0, r_cfg.height_offset};
            REG_MIN_HGT:    prdata = {32'b0, r_cfg.min_height};
            REG_MAX_HGT:    prdata = {32'b0, r_cfg.max_height};
            REG_MAX_RANGE:  prdata = {33'b0, r_cfg.max_range};
            default:        prdata = '0;
        endcase
    end

endmodule

@@ rtl/shoc_front.sv @@
module shoc_front
    import shoc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  t_pixel              i_pixel,
    input  t_cfg                i_cfg,
    output logic                o_vld,
    output logic [RANGE_DW-1:0] o_rem,
    output logic [RANGE_QW-1:0] o_low,
    output logic [RANGE_DW-1:0] o_den,
    output t_side_rng           o_side
);

    // stage 1: denominator, bounds, coefficient products
    logic signed [20:0]         ucc, urc, ukc, wcc, wrc, wkc;
    logic signed [10:0]         col_s, row_s;
    logic signed [26:0]         n_den;
    logic                       n_skip1;
    logic signed [31:0]         n_pu_c, n_pu_r, n_pw_c, n_pw_r;

    logic                       r1_vld;
    logic                       r1_skip;
    logic [RANGE_DW-1:0]        r1_den;
    logic signed [31:0]         r1_pu_c, r1_pu_r, r1_pw_c, r1_pw_r;

    // stage 2: linear sums, overflow check
    logic [47:0]                num;
    logic signed [LIN_W-1:0]    n_u, n_w;
    logic                       n_ovf;

    logic                       r2_vld;
    logic [RANGE_DW-1:0]        r2_rem;
    logic [RANGE_QW-1:0]        r2_low;
    logic [RANGE_DW-1:0]        r2_den;
    t_side_rng                  r2_side;

    assign ucc   = i_cfg.up_ray_coeffs[20:0];
    assign urc   = i_cfg.up_ray_coeffs[41:21];
    assign ukc   = i_cfg.up_ray_coeffs[62:42];
    assign wcc   = i_cfg.axis_ray_coeffs[20:0];
    assign wrc   = i_cfg.axis_ray_coeffs[41:21];
    assign wkc   = i_cfg.axis_ray_coeffs[62:42];
    assign col_s = $signed({1'b0, i_pixel.pixel_col});
    assign row_s = $signed({1'b0, i_pixel.pixel_row});

    always_comb begin
        n_den   = $signed({3'b0, i_pixel.disparity, 8'b0}) - i_cfg.disp_center;
        n_skip1 = (int'(i_pixel.pixel_col) >= IMAGE_COLS) ||
                  (int'(i_pixel.pixel_row) >= IMAGE_ROWS) ||
                  (i_pixel.disparity == NO_DISPARITY) ||
                  n_den[26] || (n_den == '0);
        n_pu_c  = ucc * col_s;
        n_pu_r  = urc * row_s;
        n_pw_c  = wcc * col_s;
        n_pw_r  = wrc * row_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_skip <= n_skip1;
        r1_den  <= n_den[RANGE_DW-1:0];
        r1_pu_c <= n_pu_c;
        r1_pu_r <= n_pu_r;
        r1_pw_c <= n_pw_c;
        r1_pw_r <= n_pw_r;
    end

    assign num = {i_cfg.baseline_num, 8'b0};

    always_comb begin
        n_u   = r1_pu_c + r1_pu_r + ukc;
        n_w   = r1_pw_c + r1_pw_r + wkc;
        // range at or above 2^31 always exceeds max_range
        n_ovf = {9'b0, num[47:RANGE_QW]} >= r1_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_rem       <= {9'b0, num[47:RANGE_QW]};
        r2_low       <= num[RANGE_QW-1:0];
        r2_den       <= r1_den;
        r2_side.skip <= r1_skip || n_ovf;
        r2_side.u    <= n_u;
        r2_side.w    <= n_w;
    end

    assign o_vld  = r2_vld;
    assign o_rem  = r2_rem;
    assign o_low  = r2_low;
    assign o_den  = r2_den;
    assign o_side = r2_side;

endmodule

@@ rtl/shoc_div.sv @@
module shoc_div #(
    parameter int QW = 31,
    parameter int DW = 26,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    // one quotient bit per stage; i_rem must be below i_den
    logic          s_vld  [0:QW];
    logic [DW-1:0] s_rem  [0:QW];
    logic [QW-1:0] s_low  [0:QW];
    logic [QW-1:0] s_quo  [0:QW];
    logic [DW-1:0] s_den  [0:QW];
    logic [SW-1:0] s_side [0:QW];

    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = i_rem;
    assign s_low[0]  = i_low;
    assign s_quo[0]  = '0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   n_trial;
        logic [DW:0]   n_diff;
        logic          n_fit;
        logic          r_vld;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_low;
        logic [QW-1:0] r_quo;
        logic [DW-1:0] r_den;
        logic [SW-1:0] r_side;

        assign n_trial = {s_rem[k], s_low[k][QW-1]};
        assign n_diff  = n_trial - {1'b0, s_den[k]};
        assign n_fit   = n_trial >= {1'b0, s_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= s_vld[k];
            end
            r_rem  <= n_fit ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_low  <= s_low[k] << 1;
            r_quo  <= {s_quo[k][QW-2:0], n_fit};
            r_den  <= s_den[k];
            r_side <= s_side[k];
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rem[k+1]  = r_rem;
        assign s_low[k+1]  = r_low;
        assign s_quo[k+1]  = r_quo;
        assign s_den[k+1]  = r_den;
        assign s_side[k+1] = r_side;
    end

    assign o_vld  = s_vld[QW];
    assign o_quo  = s_quo[QW];
    assign o_side = s_side[QW];

endmodule

@@ rtl/shoc_mul.sv @@
module shoc_mul
    import shoc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [RANGE_QW-1:0] i_range,
    input  t_side_rng           i_side,
    input  t_cfg                i_cfg,
    output logic                o_vld,
    output logic [HGT_DW-1:0]   o_rem,
    output logic [HGT_QW-1:0]   o_low,
    output logic [HGT_DW-1:0]   o_den,
    output t_side_hgt           o_side
);

    logic signed [63:0]      n_p;
    logic                    n_skip;

    logic                    r1_vld;
    logic                    r1_skip;
    logic signed [63:0]      r1_p;
    logic signed [LIN_W-1:0] r1_w;

    logic [63:0]             p_mag;
    logic [HGT_DW-1:0]       w_mag;

    logic                    r2_vld;
    logic [HGT_DW-1:0]       r2_rem;
    logic [HGT_QW-1:0]       r2_low;
    logic [HGT_DW-1:0]       r2_den;
    t_side_hgt               r2_side;

    always_comb begin
        n_p    = $signed({1'b0, i_range}) * i_side.u;
        n_skip = i_side.skip || (i_range > i_cfg.max_range) || (i_side.w == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_skip <= n_skip;
        r1_p    <= n_p;
        r1_w    <= i_side.w;
    end

    assign p_mag = r1_p[63] ? 64'(-r1_p) : 64'(r1_p);
    assign w_mag = r1_w[LIN_W-1] ? HGT_DW'(-r1_w) : HGT_DW'(r1_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_rem       <= {2'b0, p_mag[63:HGT_QW]};
        r2_low       <= p_mag[HGT_QW-1:0];
        r2_den       <= w_mag;
        r2_side.skip <= r1_skip;
        r2_side.neg  <= r1_p[63] ^ r1_w[LIN_W-1];
        // quotient of 2^33 or more saturates the height anyway
        r2_side.ovf  <= {2'b0, p_mag[63:HGT_QW]} >= w_mag;
    end

    assign o_vld  = r2_vld;
    assign o_rem  = r2_rem;
    assign o_low  = r2_low;
    assign o_den  = r2_den;
    assign o_side = r2_side;

endmodule

@@ rtl/shoc_fin.sv @@
module shoc_fin
    import shoc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [HGT_QW-1:0] i_quo,
    input  t_side_hgt         i_side,
    input  t_cfg              i_cfg,
    output logic              o_strobe,
    output t_result           o_result
);

    logic [HGT_QW:0]          qmag;
    logic signed [HGT_QW+1:0] q;
    logic signed [HGT_QW+2:0] hsum;
    logic signed [31:0]       hsat;
    t_result                  n_res;
    logic                     r_strobe;
    t_result                  r_res;

    always_comb begin
        qmag = i_side.ovf ? {1'b1, {HGT_QW{1'b0}}} : {1'b0, i_quo};
        q    = i_side.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        hsum = q + i_cfg.height_offset;
        if (hsum > $signed(36'sh0_7FFF_FFFF)) begin
            hsat = 32'sh7FFF_FFFF;
        end else if (hsum < $signed(-36'sh0_8000_0000)) begin
            hsat = -32'sh8000_0000;
        end else begin
            hsat = hsum[31:0];
        end
        if (i_side.skip) begin
            n_res = '0;
        end else begin
            n_res.measured = 1'b1;
            n_res.obstacle = (hsat < i_cfg.min_height) || (hsat > i_cfg.max_height);
            n_res.height   = hsat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

@@ rtl/stereo_height_obstacle_classifier_top.sv @@
// channel   | ports                               | handshake
// pixel in  | start, busy, i_pixel                | beat on start && !busy
// result    | o_strobe, o_result                  | beat on o_strobe, no back-pressure
// config    | psel penable pwrite paddr pwdata    | APB write, pready tied high
//
// One pixel per cycle, fully pipelined; busy is never raised.
// Pipeline: 2 front stages, 31 range divide stages, 2 multiply and
// sign stages, 33 height divide stages, 1 output stage.
// Synchronous active-low reset clears valid bits and config registers, but sets max_range to all ones.
module stereo_height_obstacle_classifier_top
    import shoc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_pixel                i_pixel,
    output logic                  o_strobe,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg                cfg;

    logic                f_vld;
    logic [RANGE_DW-1:0] f_rem;
    logic [RANGE_QW-1:0] f_low;
    logic [RANGE_DW-1:0] f_den;
    t_side_rng           f_side;

    logic                r_vld;
    logic [RANGE_QW-1:0] r_range;
    t_side_rng           r_side;

    logic                m_vld;
    logic [HGT_DW-1:0]   m_rem;
    logic [HGT_QW-1:0]   m_low;
    logic [HGT_DW-1:0]   m_den;
    t_side_hgt           m_side;

    logic                h_vld;
    logic [HGT_QW-1:0]   h_quo;
    t_side_hgt           h_side;

    assign busy = 1'b0;

    shoc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    shoc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_pixel (i_pixel),
        .i_cfg   (cfg),
        .o_vld   (f_vld),
        .o_rem   (f_rem),
        .o_low   (f_low),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    shoc_div #(
        .QW (RANGE_QW),
        .DW (RANGE_DW),
        .SW ($bits(t_side_rng))
    ) u_div_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_rem   (f_rem),
        .i_low   (f_low),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_vld   (r_vld),
        .o_quo   (r_range),
        .o_side  (r_side)
    );

    shoc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_range (r_range),
        .i_side  (r_side),
        .i_cfg   (cfg),
        .o_vld   (m_vld),
        .o_rem   (m_rem),
        .o_low   (m_low),
        .o_den   (m_den),
        .o_side  (m_side)
    );

    shoc_div #(
        .QW (HGT_QW),
        .DW (HGT_DW),
        .SW ($bits(t_side_hgt))
    ) u_div_hgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (m_vld),
        .i_rem   (m_rem),
        .i_low   (m_low),
        .i_den   (m_den),
        .i_side  (m_side),
        .o_vld   (h_vld),
        .o_quo   (h_quo),
        .o_side  (h_side)
    );

    shoc_fin u_fin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (h_vld),
        .i_quo    (h_quo),
        .i_side   (h_side),
        .i_cfg    (cfg),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import shoc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PIPE_DRAIN  = 80;

    typedef struct {
        t_pixel  pix;
        bit      known;
        t_result res;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_pixel                i_pixel;
    logic                  o_strobe;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    t_cfg      cfg_shadow;
    t_result   height_q[$];
    int        mismatches;
    int        cycles;
    int        idle_pct;
    stim_row_t dir_rows[$];

    stereo_height_obstacle_classifier_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint ray_term(logic [62:0] coeffs, longint col, longint row);
        longint cc;
        longint rc;
        longint kc;
        cc = longint'($signed(coeffs[20:0]));
        rc = longint'($signed(coeffs[41:21]));
        kc = longint'($signed(coeffs[62:42]));
        return cc * col + rc * row + kc;
    endfunction

    function automatic t_result classify_pixel(t_pixel p);
        t_result r;
        longint den;
        longint unsigned rng;
        longint u;
        longint w;
        longint h;
        r = '0;
        if (p.pixel_col >= IMAGE_COLS || p.pixel_row >= IMAGE_ROWS) return r;
        if (p.disparity == NO_DISPARITY) return r;
        den = longint'(p.disparity) * 256 - longint'(cfg_shadow.disp_center);
        if (den <= 0) return r;
        rng = (longint'(cfg_shadow.baseline_num) << 8) / longint'(den);
        if (rng > longint'(cfg_shadow.max_range)) return r;
        w = ray_term(cfg_shadow.axis_ray_coeffs, p.pixel_col, p.pixel_row);
        if (w == 0) return r;
        u = ray_term(cfg_shadow.up_ray_coeffs, p.pixel_col, p.pixel_row);
        h = (longint'(rng) * u) / w + longint'(cfg_shadow.height_offset);
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        r.measured = 1'b1;
        r.obstacle = (h < longint'(cfg_shadow.min_height) ||
                      h > longint'(cfg_shadow.max_height));
        r.height   = h[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (cycles >= CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (height_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", o_result);
            end else begin
                t_result e;
                e = height_q.pop_front();
                if (o_result.measured !== e.measured || o_result.obstacle !== e.obstacle ||
                    o_result.height !== e.height) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp m=%b o=%b h=%h got m=%b o=%b h=%h",
                                 e.measured, e.obstacle, e.height, o_result.measured,
                                 o_result.obstacle, o_result.height);
                end
            end
        end
    end

    task automatic send_pixel(t_pixel p, bit known, t_result res);
        bit was_busy;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= p;
        forever begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
            if (!was_busy) break;
        end
        height_q.push_back(known ? res : classify_pixel(p));
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 3;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_UP_RAY:     cfg_shadow.up_ray_coeffs   = v[62:0];
            REG_AXIS_RAY:   cfg_shadow.axis_ray_coeffs = v[62:0];
            REG_BASELINE:   cfg_shadow.baseline_num    = v[39:0];
            REG_DISP_CTR:   cfg_shadow.disp_center     = v[24:0];
            REG_HGT_OFFSET: cfg_shadow.height_offset   = v[31:0];
            REG_MIN_HGT:    cfg_shadow.min_height      = v[31:0];
            REG_MAX_HGT:    cfg_shadow.max_height      = v[31:0];
            default:        cfg_shadow.max_range       = v[30:0];
        endcase
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (height_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [62:0] rand_coeffs(int mode);
        logic [20:0] c [3];
        for (int k = 0; k < 3; k++) begin
            case (mode)
                0: c[k] = 21'($urandom);
                1: c[k] = 21'($signed($urandom_range(2048)) - 1024) << $urandom_range(9);
                default: c[k] = $urandom_range(1) ? 21'h0FFFFF : 21'h100000;
            endcase
        end
        return {c[2], c[1], c[0]};
    endfunction

    task automatic write_all(logic [62:0] up, logic [62:0] ax, logic [39:0] bl,
                             logic [24:0] dc, logic [31:0] ho, logic [31:0] mn,
                             logic [31:0] mx, logic [30:0] mr);
        cfg_write(REG_UP_RAY, {1'($urandom_range(1)), up});
        cfg_write(REG_AXIS_RAY, {1'b0, ax});
        cfg_write(REG_BASELINE, {24'($urandom), bl});
        cfg_write(REG_DISP_CTR, {39'd0, dc});
        cfg_write(REG_HGT_OFFSET, {32'($urandom), ho});
        cfg_write(REG_MIN_HGT, {32'd0, mn});
        cfg_write(REG_MAX_HGT, {32'd0, mx});
        cfg_write(REG_MAX_RANGE, {33'd0, mr});
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p.pixel_col = 10'($urandom);
        p.pixel_row = 10'($urandom);
        case ($urandom_range(9))
            0:       p.disparity = NO_DISPARITY;
            1:       p.disparity = 16'($urandom);
            2:       p.disparity = 16'($urandom_range(3));
            3, 4:    p.disparity = 16'($urandom_range(4095));
            default: p.disparity = 16'($urandom_range(255));
        endcase
        return p;
    endfunction

    function automatic stim_row_t mk_row(logic [9:0] c, logic [9:0] r, logic [15:0] d,
                                         bit known);
        stim_row_t s;
        s.pix   = '{pixel_col: c, pixel_row: r, disparity: d};
        s.known = known;
        s.res   = '0;
        return s;
    endfunction

    initial begin
        int phase;
        int n;
        t_result zero_res;
        zero_res   = '0;
        mismatches = 0;
        cycles     = 0;
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_pixel    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_shadow = '0;
        cfg_shadow.max_range = 31'h7FFFFFFF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: w is zero everywhere, so nothing is measured
        send_pixel(mk_row(0, 0, 100, 1).pix, 1, zero_res);
        send_pixel(mk_row(1023, 1023, 1, 1).pix, 1, zero_res);
        send_pixel(mk_row(512, 7, 0, 1).pix, 1, zero_res);
        drain_pipe();

        write_all({21'sd0, -21'sd2000, 21'sd3000}, {21'sd524288, 21'sd0, 21'sd0},
                  40'h00_0100_0000, 25'h000100, 32'h0001_0000, -32'sd65536,
                  32'sd655360, 31'h7FFFFFFF);
        dir_rows.push_back(mk_row(10, 20, 0, 1));
        dir_rows.push_back(mk_row(10, 20, 1, 1));
        dir_rows.push_back(mk_row(10, 20, NO_DISPARITY, 1));
        dir_rows.push_back(mk_row(0, 0, 2, 0));
        dir_rows.push_back(mk_row(1023, 0, 2, 0));
        dir_rows.push_back(mk_row(0, 1023, 2, 0));
        dir_rows.push_back(mk_row(1023, 1023, 65534, 0));
        dir_rows.push_back(mk_row(341, 682, 16'h5555, 0));
        dir_rows.push_back(mk_row(682, 341, 16'hAAAA, 0));
        dir_rows.push_back(mk_row(100, 900, 3, 0));
        dir_rows.push_back(mk_row(900, 100, 40, 0));
        dir_rows.push_back(mk_row(0, 0, 0, 1));
        foreach (dir_rows[k]) send_pixel(dir_rows[k].pix, dir_rows[k].known, dir_rows[k].res);
        drain_pipe();

        // extremes: huge coefficients and baseline saturate height, band inverted
        write_all({3{21'h0FFFFF}}, {21'h000001, 21'h000000, 21'h000001}, 40'hFF_FFFF_FFFF,
                  25'h1000000, 32'h7FFF_FFFF, 32'sd1000, -32'sd1000, 31'h7FFFFFFF);
        for (int k = 0; k < 8; k++)
            send_pixel(rand_pixel(), 0, zero_res);
        drain_pipe();
        write_all({3{21'h100000}}, {3{21'h100000}}, 40'd0, 25'h0FFFFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        for (int k = 0; k < 8; k++)
            send_pixel(rand_pixel(), 0, zero_res);
        drain_pipe();

        for (phase = 0; phase < 8; phase++) begin
            write_all(rand_coeffs($urandom_range(2)), rand_coeffs($urandom_range(2)),
                      $urandom_range(1) ? {8'($urandom), 32'($urandom)}
                                        : 40'($urandom_range(32'hFFFFFF)) << 8,
                      $urandom_range(1) ? 25'($urandom) : 25'($urandom_range(4096)),
                      $urandom, $signed($urandom_range(2000000)) - 1500000,
                      $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(3000000)),
                      $urandom_range(3) == 0 ? 31'($urandom) : 31'h7FFFFFFF);
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 83;
                2: idle_pct = 0;
                default: idle_pct = 23;
            endcase
            n = 210;
            for (int k = 0; k < n; k++)
                send_pixel(rand_pixel(), 0, zero_res);
            drain_pipe();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ stereo_height_obstacle_classifier_top.f @@
rtl/shoc_pkg.sv
rtl/shoc_cfg.sv
rtl/shoc_front.sv
rtl/shoc_div.sv
rtl/shoc_mul.sv
rtl/shoc_fin.sv
rtl/stereo_height_obstacle_classifier_top.sv
tb/sv/tb.sv
